### hw/rtl/pvc_pkg.sv
// ----------------------------------------------------------------------------
// pvc_pkg
// Shared types, constants and codes of the velocity PID controller.
// ----------------------------------------------------------------------------
`default_nettype none

package pvc_pkg;

  // value format: signed Q16.16
  localparam int VALUE_W   = 32;
  localparam int FRAC_BITS = 16;
  localparam int INTEG_W   = 48;
  localparam int ACC_W     = 64;
  localparam int IPART_W   = 80;
  localparam int PROD_W    = 2 * VALUE_W;

  // rate / 60 by reciprocal: q0 = (|rate| * RATE_RECIP) >> RECIP_SHIFT, then one fixup
  localparam int              RATE_DIV    = 60;
  localparam int              RECIP_SHIFT = 37;
  localparam logic [31:0]     RATE_RECIP  = 32'd2290649224;
  localparam int              RQ_W        = 26;

  // configuration port
  localparam int CFG_W     = 32;
  localparam int REG_IDX_W = 3;
  localparam int IVL_W     = 8;
  localparam int TOL_W     = 31;

  localparam logic [IVL_W-1:0] INTERVAL_RESET  = 8'd10;
  localparam logic [TOL_W-1:0] TOLERANCE_RESET = 31'd327680;

  // serial divider length
  localparam int DIV_STEPS = VALUE_W;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_GAIN_P    = 3'd0,
    REG_GAIN_I    = 3'd1,
    REG_GAIN_D    = 3'd2,
    REG_INTERVAL  = 3'd3,
    REG_TOLERANCE = 3'd4
  } pvc_reg_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] target_speed;
    logic signed [VALUE_W-1:0] measured_rate;
    logic        [VALUE_W-1:0] now_seconds;
  } pvc_in_t;

  typedef struct packed {
    logic                      updated;
    logic signed [VALUE_W-1:0] drive_out;
    logic signed [VALUE_W-1:0] error_now;
    logic                      at_target;
  } pvc_out_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CHECK,
    S_RATE_MUL,
    S_RATE_FIX,
    S_ERR,
    S_INT_MUL,
    S_INT_SAT,
    S_INT_ACC,
    S_P_MUL,
    S_P_ACC,
    S_I_MUL_LO,
    S_I_ACC_LO,
    S_I_MUL_HI,
    S_I_ACC_HI,
    S_I_ADD,
    S_D_WAIT,
    S_D_SAT,
    S_D_MUL,
    S_D_ACC,
    S_FINISH,
    S_OUT
  } pvc_state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CHECK,
    OP_RATE_MUL,
    OP_RATE_FIX,
    OP_ERR,
    OP_INT_MUL,
    OP_INT_SAT,
    OP_INT_ACC,
    OP_P_MUL,
    OP_P_ACC,
    OP_I_MUL_LO,
    OP_I_ACC_LO,
    OP_I_MUL_HI,
    OP_I_ACC_HI,
    OP_I_ADD,
    OP_D_SAT,
    OP_D_MUL,
    OP_D_ACC,
    OP_COMMIT
  } pvc_op_t;

  // controller to datapath
  typedef struct packed {
    logic    take;
    logic    out_load;
    pvc_op_t op;
  } pvc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic upd;
    logic div_busy;
  } pvc_sts_t;

endpackage

`default_nettype wire

### hw/rtl/pvc_divider.sv
// ----------------------------------------------------------------------------
// pvc_divider
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [pvc_pkg::VALUE_W-1:0] dividend,
  input  wire logic [pvc_pkg::VALUE_W-1:0] divisor,
  output logic                            busy,
  output logic      [pvc_pkg::VALUE_W-1:0] quotient
);
  import pvc_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS + 1);

  logic [CNT_W-1:0]   cnt;
  logic [VALUE_W-1:0] quo;
  logic [VALUE_W-1:0] rem;
  logic [VALUE_W-1:0] dvs;
  logic [VALUE_W:0]   shifted;
  logic               fits;

  assign busy     = (cnt != '0);
  assign quotient = quo;

  // one trial subtract per step
  assign shifted = {rem, quo[VALUE_W-1]};
  assign fits    = (shifted >= {1'b0, dvs});

  // step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(DIV_STEPS);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  // partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= VALUE_W'(shifted - {1'b0, dvs});
      end else begin
        rem <= shifted[VALUE_W-1:0];
      end
      quo <= {quo[VALUE_W-2:0], fits};
    end
  end

  // a start always opens a full run
  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    start |=> (cnt == CNT_W'(DIV_STEPS)))
    else $error("divider did not start a full run");

  // finished remainder stays below the divisor
  a_rem_range: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> (rem < dvs))
    else $error("divider remainder not below divisor");

endmodule

`default_nettype wire

### hw/rtl/pvc_datapath.sv
// ----------------------------------------------------------------------------
// pvc_datapath
// Registers, shared 32x32 multiplier, divider and accumulator of the
// controller; each step is selected by the op code from the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_write,
  input  wire logic [pvc_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [pvc_pkg::CFG_W-1:0]    cfg_data,
  input  wire pvc_pkg::pvc_in_t             item,
  output pvc_pkg::pvc_out_t                 result,
  input  wire pvc_pkg::pvc_cmd_t            cmd,
  output pvc_pkg::pvc_sts_t                 sts
);
  import pvc_pkg::*;

  localparam logic [VALUE_W-1:0] MAX32 = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] MIN32 = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [INTEG_W-1:0] MAX48 = {1'b0, {(INTEG_W-1){1'b1}}};
  localparam logic [INTEG_W-1:0] MIN48 = {1'b1, {(INTEG_W-1){1'b0}}};

  function automatic logic [VALUE_W-1:0] mag32(input logic [VALUE_W-1:0] v);
    return v[VALUE_W-1] ? (~v + VALUE_W'(1)) : v;
  endfunction

  function automatic logic [ACC_W-1:0] apply_sign(input logic [ACC_W-1:0] m, input logic neg);
    return neg ? (~m + ACC_W'(1)) : m;
  endfunction

  // configuration registers
  logic [VALUE_W-1:0] gain_p;
  logic [VALUE_W-1:0] gain_i;
  logic [VALUE_W-1:0] gain_d;
  logic [IVL_W-1:0]   interval;
  logic [TOL_W-1:0]   tolerance;

  // controller state kept between items
  logic [INTEG_W-1:0] integ;
  logic [VALUE_W-1:0] error_r;
  logic [VALUE_W-1:0] last_time;
  logic [VALUE_W-1:0] last_out;

  // working registers of one item
  logic [VALUE_W-1:0] target_r;
  logic [VALUE_W-1:0] rate_r;
  logic [VALUE_W-1:0] now_r;
  logic               upd_r;
  logic [RQ_W-1:0]    rate_q;
  logic [VALUE_W-1:0] err_new;
  logic [INTEG_W-1:0] int_term;
  logic [ACC_W-1:0]   acc;
  logic [IPART_W-1:0] ipart;
  logic               deriv_neg;
  logic [VALUE_W-1:0] deriv;
  logic [PROD_W-1:0]  prod;

  // combinational helpers
  logic [VALUE_W-1:0] mul_a;
  logic [VALUE_W-1:0] mul_b;
  logic [VALUE_W-1:0] rate_mag;
  logic [VALUE_W-1:0] dt;
  logic [INTEG_W-1:0] integ_mag;
  logic [RQ_W-1:0]    q0;
  logic [VALUE_W-1:0] q60;
  logic [VALUE_W-1:0] rem60;
  logic [RQ_W-1:0]    rate_q_next;
  logic [VALUE_W:0]   signed_q;
  logic [VALUE_W:0]   err_diff;
  logic [VALUE_W-1:0] err_sat;
  logic [VALUE_W:0]   d_diff;
  logic [VALUE_W-1:0] d_mag;
  logic [INTEG_W-1:0] int_term_next;
  logic [INTEG_W:0]   int_sum;
  logic [INTEG_W-1:0] integ_next;
  logic [ACC_W-1:0]   frac_term;
  logic [ACC_W-1:0]   ipart_term;
  logic [VALUE_W-1:0] deriv_next;
  logic [VALUE_W-1:0] out_sat;
  logic               div_start;
  logic               div_busy;
  logic [VALUE_W-1:0] div_quo;

  assign rate_mag  = mag32(rate_r);
  assign dt        = now_r - last_time;
  assign integ_mag = integ[INTEG_W-1] ? (~integ + INTEG_W'(1)) : integ;

  // update test at 33 bits, no wrap
  assign sts.upd      = ({1'b0, now_r} > ({1'b0, last_time} + (VALUE_W+1)'(interval)));
  assign sts.div_busy = div_busy;

  // multiplier operand select
  always_comb begin
    mul_a = mag32(gain_p);
    mul_b = mag32(err_new);
    unique case (cmd.op)
      OP_RATE_MUL: begin
        mul_a = rate_mag;
        mul_b = RATE_RECIP;
      end
      OP_INT_MUL: begin
        mul_a = mag32(err_new);
        mul_b = dt;
      end
      OP_I_MUL_LO: begin
        mul_a = mag32(gain_i);
        mul_b = integ_mag[VALUE_W-1:0];
      end
      OP_I_MUL_HI: begin
        mul_a = mag32(gain_i);
        mul_b = {{(2*VALUE_W-INTEG_W){1'b0}}, integ_mag[INTEG_W-1:VALUE_W]};
      end
      OP_D_MUL: begin
        mul_a = mag32(gain_d);
        mul_b = mag32(deriv);
      end
      default: begin
        mul_a = mag32(gain_p);
        mul_b = mag32(err_new);
      end
    endcase
  end

  // rate / 60: reciprocal estimate is exact or one low
  assign q0          = prod[RECIP_SHIFT +: RQ_W];
  assign q60         = {q0, 6'b0} - {4'b0, q0, 2'b0};
  assign rem60       = rate_mag - q60;
  assign rate_q_next = (rem60 >= VALUE_W'(RATE_DIV)) ? (q0 + RQ_W'(1)) : q0;

  // error = target - rate/60, saturated
  assign signed_q = rate_r[VALUE_W-1] ? ((VALUE_W+1)'(0) - (VALUE_W+1)'(rate_q))
                                      : (VALUE_W+1)'(rate_q);
  assign err_diff = {target_r[VALUE_W-1], target_r} - signed_q;
  assign err_sat  = (err_diff[VALUE_W] != err_diff[VALUE_W-1])
                    ? (err_diff[VALUE_W] ? MIN32 : MAX32) : err_diff[VALUE_W-1:0];

  // derivative numerator, magnitude goes to the divider
  assign d_diff    = {err_new[VALUE_W-1], err_new} - {error_r[VALUE_W-1], error_r};
  assign d_mag     = d_diff[VALUE_W] ? VALUE_W'(~d_diff + (VALUE_W+1)'(1))
                                     : d_diff[VALUE_W-1:0];
  assign div_start = (cmd.op == OP_INT_MUL);

  // error * dt clamped to the integral width
  always_comb begin
    if (err_new[VALUE_W-1]) begin
      int_term_next = (prod > PROD_W'(MIN48)) ? MIN48 : (~prod[INTEG_W-1:0] + INTEG_W'(1));
    end else begin
      int_term_next = (prod > PROD_W'(MAX48)) ? MAX48 : prod[INTEG_W-1:0];
    end
  end

  assign int_sum    = {integ[INTEG_W-1], integ} + {int_term[INTEG_W-1], int_term};
  assign integ_next = (int_sum[INTEG_W] != int_sum[INTEG_W-1])
                      ? (int_sum[INTEG_W] ? MIN48 : MAX48) : int_sum[INTEG_W-1:0];

  // gain terms, product shifted down by the fraction bits
  always_comb begin
    if (cmd.op == OP_D_ACC) begin
      frac_term = apply_sign(ACC_W'(prod[PROD_W-1:FRAC_BITS]),
                             gain_d[VALUE_W-1] ^ deriv[VALUE_W-1]);
    end else begin
      frac_term = apply_sign(ACC_W'(prod[PROD_W-1:FRAC_BITS]),
                             gain_p[VALUE_W-1] ^ err_new[VALUE_W-1]);
    end
  end

  assign ipart_term = apply_sign({1'b0, ipart[IPART_W-2:FRAC_BITS]},
                                 gain_i[VALUE_W-1] ^ integ[INTEG_W-1]);

  // derivative quotient with sign, saturated
  always_comb begin
    if (deriv_neg) begin
      deriv_next = (div_quo > MIN32) ? MIN32 : (~div_quo + VALUE_W'(1));
    end else begin
      deriv_next = (div_quo > MAX32) ? MAX32 : div_quo;
    end
  end

  // final output clamp
  always_comb begin
    if (acc[ACC_W-1] && !(&acc[ACC_W-2:VALUE_W-1])) begin
      out_sat = MIN32;
    end else if (!acc[ACC_W-1] && (|acc[ACC_W-2:VALUE_W-1])) begin
      out_sat = MAX32;
    end else begin
      out_sat = acc[VALUE_W-1:0];
    end
  end

  // configuration and carried state
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p    <= '0;
      gain_i    <= '0;
      gain_d    <= '0;
      interval  <= INTERVAL_RESET;
      tolerance <= TOLERANCE_RESET;
      integ     <= '0;
      error_r   <= '0;
      last_time <= '0;
      last_out  <= '0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_GAIN_P:    gain_p    <= cfg_data[VALUE_W-1:0];
          REG_GAIN_I:    gain_i    <= cfg_data[VALUE_W-1:0];
          REG_GAIN_D:    gain_d    <= cfg_data[VALUE_W-1:0];
          REG_INTERVAL:  interval  <= cfg_data[IVL_W-1:0];
          REG_TOLERANCE: tolerance <= cfg_data[TOL_W-1:0];
          default: ;
        endcase
      end
      if ((cmd.op == OP_ERR) && (target_r == '0)) begin
        integ <= '0;
      end else if (cmd.op == OP_INT_ACC) begin
        integ <= integ_next;
      end
      if (cmd.op == OP_COMMIT) begin
        last_out  <= out_sat;
        error_r   <= err_new;
        last_time <= now_r;
      end
    end
  end

  // multiplier output register
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // per-item working registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      target_r <= item.target_speed;
      rate_r   <= item.measured_rate;
      now_r    <= item.now_seconds;
    end
    unique case (cmd.op)
      OP_CHECK:    upd_r     <= sts.upd;
      OP_RATE_FIX: rate_q    <= rate_q_next;
      OP_ERR:      err_new   <= err_sat;
      OP_INT_MUL:  deriv_neg <= d_diff[VALUE_W];
      OP_INT_SAT:  int_term  <= int_term_next;
      OP_P_ACC:    acc       <= frac_term;
      OP_I_ACC_LO: ipart     <= IPART_W'(prod);
      OP_I_ACC_HI: ipart     <= ipart + {prod[INTEG_W-1:0], {VALUE_W{1'b0}}};
      OP_I_ADD:    acc       <= acc + ipart_term;
      OP_D_SAT:    deriv     <= deriv_next;
      OP_D_ACC:    acc       <= acc + frac_term;
      default: ;
    endcase
    if (cmd.out_load) begin
      result.updated   <= upd_r;
      result.drive_out <= last_out;
      result.error_now <= error_r;
      result.at_target <= (mag32(error_r) <= {1'b0, tolerance});
    end
  end

  pvc_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (d_mag),
    .divisor  (dt),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  // state only moves on items that passed the interval test
  a_commit_upd: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_COMMIT) |-> upd_r)
    else $error("commit without a passed interval test");

endmodule

`default_nettype wire

### hw/rtl/pvc_ctrl.sv
// ----------------------------------------------------------------------------
// pvc_ctrl
// Sequencer of the controller: steps the datapath through one update and
// owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module pvc_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  output logic                   item_stall,
  output logic                   result_valid,
  input  wire logic              result_stall,
  input  wire pvc_pkg::pvc_sts_t sts,
  output pvc_pkg::pvc_cmd_t      cmd
);
  import pvc_pkg::*;

  pvc_state_t state;
  pvc_state_t state_next;
  logic       result_valid_next;

  // new request only taken while nothing is in work
  assign item_stall = (state != S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:     if (item_valid) state_next = S_CHECK;
      S_CHECK:    state_next = sts.upd ? S_RATE_MUL : S_OUT;
      S_RATE_MUL: state_next = S_RATE_FIX;
      S_RATE_FIX: state_next = S_ERR;
      S_ERR:      state_next = S_INT_MUL;
      S_INT_MUL:  state_next = S_INT_SAT;
      S_INT_SAT:  state_next = S_INT_ACC;
      S_INT_ACC:  state_next = S_P_MUL;
      S_P_MUL:    state_next = S_P_ACC;
      S_P_ACC:    state_next = S_I_MUL_LO;
      S_I_MUL_LO: state_next = S_I_ACC_LO;
      S_I_ACC_LO: state_next = S_I_MUL_HI;
      S_I_MUL_HI: state_next = S_I_ACC_HI;
      S_I_ACC_HI: state_next = S_I_ADD;
      S_I_ADD:    state_next = S_D_WAIT;
      S_D_WAIT:   if (!sts.div_busy) state_next = S_D_SAT;
      S_D_SAT:    state_next = S_D_MUL;
      S_D_MUL:    state_next = S_D_ACC;
      S_D_ACC:    state_next = S_FINISH;
      S_FINISH:   state_next = S_OUT;
      S_OUT:      if (!result_valid || !result_stall) state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd.take     = (state == S_IDLE) && item_valid;
    cmd.out_load = (state == S_OUT) && (!result_valid || !result_stall);
    unique case (state)
      S_CHECK:    cmd.op = OP_CHECK;
      S_RATE_MUL: cmd.op = OP_RATE_MUL;
      S_RATE_FIX: cmd.op = OP_RATE_FIX;
      S_ERR:      cmd.op = OP_ERR;
      S_INT_MUL:  cmd.op = OP_INT_MUL;
      S_INT_SAT:  cmd.op = OP_INT_SAT;
      S_INT_ACC:  cmd.op = OP_INT_ACC;
      S_P_MUL:    cmd.op = OP_P_MUL;
      S_P_ACC:    cmd.op = OP_P_ACC;
      S_I_MUL_LO: cmd.op = OP_I_MUL_LO;
      S_I_ACC_LO: cmd.op = OP_I_ACC_LO;
      S_I_MUL_HI: cmd.op = OP_I_MUL_HI;
      S_I_ACC_HI: cmd.op = OP_I_ACC_HI;
      S_I_ADD:    cmd.op = OP_I_ADD;
      S_D_SAT:    cmd.op = OP_D_SAT;
      S_D_MUL:    cmd.op = OP_D_MUL;
      S_D_ACC:    cmd.op = OP_D_ACC;
      S_FINISH:   cmd.op = OP_COMMIT;
      default:    cmd.op = OP_NONE;
    endcase
  end

  // result register: loaded, or held while stalled
  always_comb begin
    if (cmd.out_load) begin
      result_valid_next = 1'b1;
    end else begin
      result_valid_next = result_valid && result_stall;
    end
  end

  // an accepted request always starts with the interval test
  a_take_check: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state == S_CHECK))
    else $error("accepted request did not enter the interval test");

  // derivative is only read once the divider has finished
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_D_SAT) |-> !sts.div_busy)
    else $error("derivative taken while divider busy");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!result_valid || !result_stall))
    else $error("result register overwritten while stalled");

endmodule

`default_nettype wire

### hw/rtl/pid_velocity_controller.sv
// ----------------------------------------------------------------------------
// pid_velocity_controller
// Velocity PID controller, signed Q16.16, one result per request.
//
//   channel  | dir | handshake                   | payload
//   ---------+-----+-----------------------------+----------------------------
//   item     | in  | item_valid / item_stall     | target, rate, now_seconds
//   result   | out | result_valid / result_stall | updated, drive, error, flag
//   cfg      | in  | cfg_write                   | cfg_index, cfg_data
//
// A request that runs an update waits for the 32-step serial divider for the
// derivative; the other multiplies share one registered 32x32 multiplier
// around it. A request that runs no update goes from the interval test
// straight to the result step.
// Reset is synchronous; it clears the carried controller state and the gains,
// and loads the interval and tolerance defaults. No clearing pass is needed.
// The result register lets a new request in while a result is stalled;
// the finished request then waits in its last step until the slot frees.
// ----------------------------------------------------------------------------
`default_nettype none

module pid_velocity_controller (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         item_valid,
  output logic                              item_stall,
  input  wire pvc_pkg::pvc_in_t             item,
  output logic                              result_valid,
  input  wire logic                         result_stall,
  output pvc_pkg::pvc_out_t                 result,
  input  wire logic                         cfg_write,
  input  wire logic [pvc_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [pvc_pkg::CFG_W-1:0]    cfg_data
);
  import pvc_pkg::*;

  pvc_cmd_t cmd;
  pvc_sts_t sts;

  // sequencer
  pvc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  // arithmetic and state
  pvc_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .result    (result),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

`default_nettype wire

### dv/pvc_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pvc_result_checker
// Watches the item, result and register ports of the velocity PID controller,
// runs its own fixed-point model of each update and compares every result
// with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module pvc_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  input  logic                          item_stall,
  input  pvc_pkg::pvc_in_t              item,
  input  logic                          result_valid,
  input  logic                          result_stall,
  input  pvc_pkg::pvc_out_t             result,
  input  logic                          cfg_write,
  input  logic [pvc_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [pvc_pkg::CFG_W-1:0]     cfg_data,
  output int                            fail_count,
  output int                            backlog
);
  import pvc_pkg::*;

  // wide enough for every exact product and sum
  typedef logic signed [127:0] wide_t;

  localparam logic [127:0] TERM_CAP = 128'd1 << 62;

  // register copies
  wide_t             kp, ki, kd;
  logic [IVL_W-1:0]  interval;
  logic [TOL_W-1:0]  tolerance;

  // controller state
  wide_t             integ, prev_err, cur_err, last_out;
  logic [31:0]       last_time;

  pvc_out_t          expected_q[$];

  initial begin
    fail_count = 0;
    backlog    = 0;
  end

  // saturate to a signed width
  function automatic wide_t clamp_w(input wide_t v, input int bits);
    wide_t hi, lo;
    hi = (128'sd1 <<< (bits - 1)) - 128'sd1;
    lo = -hi - 128'sd1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  // gain times value, dropped to the fraction point toward zero, capped at 2^62
  function automatic wide_t scaled_product(input wide_t a, input wide_t b);
    logic [127:0] ma, mb, m;
    logic         neg;
    neg = a[127] ^ b[127];
    ma  = a[127] ? -a : a;
    mb  = b[127] ? -b : b;
    m   = (ma * mb) >> FRAC_BITS;
    if (m > TERM_CAP) m = TERM_CAP;
    return neg ? -$signed(m) : $signed(m);
  endfunction

  // one request: maybe an update, always one result
  function automatic pvc_out_t pid_update(input pvc_in_t req);
    pvc_out_t    res;
    wide_t       tgt, rt, err, dt, prod, der, sum, mag;
    logic [32:0] deadline;
    logic [31:0] span;
    logic        upd;
    tgt      = $signed(req.target_speed);
    rt       = $signed(req.measured_rate);
    // exact 33-bit comparison, no wrap
    deadline = {1'b0, last_time} + {25'b0, interval};
    upd      = {1'b0, req.now_seconds} > deadline;
    if (upd) begin
      span = req.now_seconds - last_time;
      dt   = span;
      err  = clamp_w(tgt - rt / 128'sd60, VALUE_W);
      // a zero target clears the integral
      if (tgt == 0) integ = 0;
      prod  = clamp_w(err * dt, INTEG_W);
      integ = clamp_w(integ + prod, INTEG_W);
      der   = clamp_w((err - prev_err) / dt, VALUE_W);
      sum   = clamp_w(scaled_product(kp, err) + scaled_product(ki, integ), 63);
      sum   = clamp_w(sum + scaled_product(kd, der), 63);
      last_out  = clamp_w(sum, VALUE_W);
      cur_err   = err;
      prev_err  = err;
      last_time = req.now_seconds;
    end
    mag           = cur_err[127] ? -cur_err : cur_err;
    res.updated   = upd;
    res.drive_out = last_out[VALUE_W-1:0];
    res.error_now = cur_err[VALUE_W-1:0];
    res.at_target = mag <= $signed({97'b0, tolerance});
    return res;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    if (want !== got) begin
      $display("%0t checker: %s mismatch, expected %h actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // snoop register writes, results and requests
  always @(posedge clk) begin : watch
    pvc_out_t want;
    if (rst) begin
      kp        = 0;
      ki        = 0;
      kd        = 0;
      interval  = INTERVAL_RESET;
      tolerance = TOLERANCE_RESET;
      integ     = 0;
      prev_err  = 0;
      cur_err   = 0;
      last_out  = 0;
      last_time = '0;
      expected_q.delete();
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_GAIN_P:    kp = $signed(cfg_data);
          REG_GAIN_I:    ki = $signed(cfg_data);
          REG_GAIN_D:    kd = $signed(cfg_data);
          REG_INTERVAL:  interval = cfg_data[IVL_W-1:0];
          REG_TOLERANCE: tolerance = cfg_data[TOL_W-1:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_q.size() == 0) begin
          $display("%0t checker: unexpected result, expected none actual %h", $time, result);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          report_field("updated", want.updated, result.updated);
          report_field("drive_out", want.drive_out, result.drive_out);
          report_field("error_now", want.error_now, result.error_now);
          report_field("at_target", want.at_target, result.at_target);
        end
      end
      if (item_valid && !item_stall) expected_q.push_back(pid_update(item));
    end
    backlog = expected_q.size();
  end

endmodule

### dv/tb_pid_velocity_controller.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_pid_velocity_controller
// Drives the velocity PID controller with directed corner requests and
// random phases under changing gains, intervals and tolerances, with random
// gaps and result stalls; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------

module tb_pid_velocity_controller;
  import pvc_pkg::*;

  localparam int RUN_LIMIT    = 500000;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 100;

  logic                 clk;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_stall;
  pvc_in_t              item         = '0;
  logic                 result_valid;
  logic                 result_stall = 1'b0;
  pvc_out_t             result;
  logic                 cfg_write    = 1'b0;
  logic [REG_IDX_W-1:0] cfg_index    = '0;
  logic [CFG_W-1:0]     cfg_data     = '0;

  int                   fail_count;
  int                   backlog;
  int                   cycle_count  = 0;
  bit                   send_quiet   = 1'b0;
  bit                   recv_quiet   = 1'b0;
  logic [31:0]          clock_s      = '0;
  logic [IVL_W-1:0]     cur_ivl      = INTERVAL_RESET;

  pid_velocity_controller u_top (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  pvc_result_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .backlog      (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == RUN_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall before each result
  initial begin : receiver
    int hold;
    wait (rst == 1'b0);
    forever begin
      hold = recv_quiet ? 0 : $urandom_range(0, 12);
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        result_stall <= 1'b0;
      end
      do @(negedge clk); while (!result_valid);
      @(posedge clk);
    end
  end

  // one request after a random gap; returns on its accepting edge
  task automatic send_item(input logic [31:0] tgt, input logic [31:0] rate,
                           input logic [31:0] now);
    pvc_in_t req;
    int      gap;
    gap               = send_quiet ? 0 : $urandom_range(0, 12);
    req.target_speed  = tgt;
    req.measured_rate = rate;
    req.now_seconds   = now;
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item       <= req;
    item_valid <= 1'b1;
    do @(negedge clk); while (item_stall);
    @(posedge clk);
  endtask

  // stop sending until every result is back
  task automatic settle();
    item_valid <= 1'b0;
    do @(negedge clk); while (backlog != 0);
    repeat (4) @(posedge clk);
  endtask

  // write every register, plus one unmapped index that must be ignored
  task automatic load_settings(input logic [31:0] kp, input logic [31:0] ki,
                               input logic [31:0] kd, input logic [IVL_W-1:0] ivl,
                               input logic [31:0] tol_word);
    cfg_write <= 1'b1;
    cfg_index <= REG_IDX_W'($urandom_range(REG_TOLERANCE + 1, (1 << REG_IDX_W) - 1));
    cfg_data  <= $urandom();
    @(posedge clk);
    cfg_index <= REG_GAIN_P;
    cfg_data  <= kp;
    @(posedge clk);
    cfg_index <= REG_GAIN_I;
    cfg_data  <= ki;
    @(posedge clk);
    cfg_index <= REG_GAIN_D;
    cfg_data  <= kd;
    @(posedge clk);
    cfg_index <= REG_INTERVAL;
    cfg_data  <= {24'($urandom()), ivl};
    @(posedge clk);
    cfg_index <= REG_TOLERANCE;
    cfg_data  <= tol_word;
    @(posedge clk);
    cfg_write <= 1'b0;
    cur_ivl = ivl;
  endtask

  // mostly speeds within +-100.0, some extremes and raw words
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 4))
          0: return 32'h7FFF_FFFF;
          1: return 32'h8000_0000;
          2: return 32'hFFFF_FFFF;
          3: return 32'h0000_0001;
          default: return 32'h0000_0000;
        endcase
      end
      1, 2: return $urandom();
      default: return $urandom_range(0, 32'd13107200) - 32'd6553600;
    endcase
  endfunction

  function automatic logic [31:0] pick_gain();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom();
      default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
    endcase
  endfunction

  function automatic logic [IVL_W-1:0] pick_interval();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return 8'd255;
      2: return 8'd1;
      3: return IVL_W'($urandom());
      default: return IVL_W'($urandom_range(0, 30));
    endcase
  endfunction

  function automatic logic [31:0] pick_tolerance();
    case ($urandom_range(0, 4))
      0: return {$urandom_range(0, 1) == 1, 31'd0};
      1: return 32'hFFFF_FFFF;
      2: return {1'b1, TOLERANCE_RESET};
      default: return {1'($urandom()), 31'($urandom_range(0, 32'h0014_0000))};
    endcase
  endfunction

  // one random request shaped around the current interval
  task automatic send_random();
    logic [31:0] tgt, rate, now, back;
    int          roll;
    tgt  = ($urandom_range(0, 9) == 0) ? 32'h0 : pick_value();
    roll = $urandom_range(0, 9);
    if (roll < 5) rate = tgt * 32'd60 + ($urandom_range(0, 32'd39321600) - 32'd19660800);
    else if (roll < 8) rate = pick_value();
    else rate = $urandom();
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      now = clock_s + cur_ivl + 1 + $urandom_range(0, 20);
    end else if (roll < 85) begin
      now = clock_s + $urandom_range(0, cur_ivl);
    end else if (roll < 92) begin
      // clock going back
      back = $urandom_range(1, 1000);
      now  = (clock_s > back) ? clock_s - back : 32'h0;
    end else if (roll < 97) begin
      now = clock_s + $urandom_range(1, 1 << 20);
    end else begin
      now = clock_s + $urandom_range(1 << 16, 1 << 24);
    end
    if (now > clock_s) clock_s = now;
    send_item(tgt, rate, now);
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: gains zero, interval 10, tolerance 5.0
    send_item(32'h0, 32'h0, 32'd0);
    send_item(32'h0003_0000, 32'h0078_0000, 32'd10);
    send_item(32'h0003_0000, 32'h0078_0000, 32'd11);
    send_item(32'h0001_0000, 32'h0, 32'd11);
    settle();

    // unit-ish gains, no interval, zero band
    load_settings(32'h0001_0000, 32'h0000_8000, 32'h0002_0000, 8'd0, 32'h0);
    send_item(32'h0, 32'h0078_0000, 32'd12);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'd13);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'd14);
    send_item(32'h0001_0000, 32'h0, 32'd14);
    send_item(32'h0001_0000, 32'h0, 32'd5);
    send_item(32'h0, 32'h0, 32'd15);
    send_item(32'h0000_0001, 32'hFFFF_FFFF, 32'd16);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FF89, 32'd17);
    settle();

    // extreme gains, longest interval, widest band
    load_settings(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 8'd255, 32'hFFFF_FFFF);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'd273);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'd273 + (1 << 20) + 256);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'd546 + (1 << 21) + 256);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'd546 + (1 << 21) + (1 << 17) + 512);
    send_item(32'h0, 32'h7FFF_FFFF, 32'd546 + (1 << 21) + (1 << 17) + 812);
    settle();

    // opposite extremes, interval one
    load_settings(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 8'd1, {1'b0, TOLERANCE_RESET});
    clock_s = 32'd546 + (1 << 21) + (1 << 17) + 812;
    send_item(32'h7FFF_FFFF, 32'h8000_0000, clock_s + 2);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, clock_s + 2 + (1 << 20));
    send_item(32'h0001_0000, 32'h0, clock_s + 3 + (1 << 20));
    send_item(32'hFFFF_0000, 32'h0, clock_s + 4 + (1 << 20));
    clock_s = clock_s + 4 + (1 << 20);

    // random phases
    for (int phase = 0; phase < PHASES; phase++) begin
      settle();
      load_settings(pick_gain(), pick_gain(), pick_gain(), pick_interval(), pick_tolerance());
      send_quiet = (phase == 2);
      recv_quiet = (phase == 2 || phase == 5);
      if (phase == 4) clock_s = clock_s + 32'h8000_0000;
      repeat (PHASE_ITEMS) send_random();
    end
    send_quiet = 1'b0;
    recv_quiet = 1'b0;

    // top of the time range: deadline up to the 32-bit limit
    settle();
    load_settings(pick_gain(), pick_gain(), pick_gain(), 8'd255, 32'h7FFF_FFFF);
    send_item(pick_value(), pick_value(), 32'hFFFF_FF00);
    send_item(pick_value(), pick_value(), 32'hFFFF_FFFF);
    settle();
    load_settings(pick_gain(), pick_gain(), pick_gain(), 8'd0, pick_tolerance());
    send_item(pick_value(), pick_value(), 32'hFFFF_FFFF);
    send_item(pick_value(), pick_value(), 32'hFFFF_FFFF);
    repeat (3) send_item(pick_value(), pick_value(), $urandom());

    settle();
    repeat (60) @(posedge clk);
    if (fail_count == 0 && backlog == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### files.f
hw/rtl/pvc_pkg.sv
hw/rtl/pvc_divider.sv
hw/rtl/pvc_datapath.sv
hw/rtl/pvc_ctrl.sv
hw/rtl/pid_velocity_controller.sv
dv/pvc_result_checker.sv
dv/tb_pid_velocity_controller.sv
